@@ rtl/core/b2d_pkg.sv @@
// Shared constants and types for the binary-to-decimal ASCII converter.
// No dependencies; imported by every module of the block.
package b2d_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 20;

    localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
    localparam int ND_W      = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W    = $clog2(VALUE_BITS);

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 5;
    localparam int LEN_W     = 8;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef logic [3:0] digit_t;

    // Control broadcast to every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } chain_ctrl_t;

endpackage

@@ rtl/core/b2d_cell.sv @@
// One BCD digit cell of the double-dabble chain.
// Depends on b2d_pkg.
module b2d_cell (
    input  logic                aclk,
    input  b2d_pkg::chain_ctrl_t ctrl,
    input  logic                bit_in,
    output logic                bit_out,
    output b2d_pkg::digit_t     digit
);
    import b2d_pkg::*;

    digit_t digit_reg;
    digit_t corrected;
    digit_t digit_next;

    // Add 3 to digits of 5 and above so the shift carries into the next decade.
    always_comb begin
        corrected  = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        digit_next = {corrected[2:0], bit_in};
        bit_out    = corrected[3];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            digit_reg <= '0;
        end else if (ctrl.shift) begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

@@ rtl/core/b2d_chain.sv @@
// Row of BCD digit cells, least significant decade at index 0.
// Depends on b2d_pkg and b2d_cell.
module b2d_chain (
    input  logic                aclk,
    input  b2d_pkg::chain_ctrl_t ctrl,
    input  logic                bit_in,
    output b2d_pkg::digit_t     digits [b2d_pkg::MAX_DIGITS]
);
    import b2d_pkg::*;

    logic carry [MAX_DIGITS];

    assign carry[0] = bit_in;

    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        if (i < MAX_DIGITS - 1) begin : g_mid
            b2d_cell u_cell (
                .aclk   (aclk),
                .ctrl   (ctrl),
                .bit_in (carry[i]),
                .bit_out(carry[i+1]),
                .digit  (digits[i])
            );
        end else begin : g_top
            // The top decade never overflows for VALUE_BITS-wide operands.
            b2d_cell u_cell (
                .aclk   (aclk),
                .ctrl   (ctrl),
                .bit_in (carry[i]),
                .bit_out(),
                .digit  (digits[i])
            );
        end
    end

endmodule

@@ rtl/core/binary_to_decimal_ascii_top.sv @@
// Top level of the binary-to-decimal ASCII converter: handshake, control, output register.
// Depends on b2d_pkg and b2d_chain (which uses b2d_cell).
//
// Usage: each input word carries a 64-bit operand, a signed flag, a buffer
// length and a terminator flag. The block converts the magnitude with a row
// of 20 BCD cells (double dabble), shifting one operand bit in per cycle,
// then streams the text out one character per word, most significant first:
// an optional '-', the digits ("0" for zero) and an optional NUL. The final
// word has m_tlast set and carries the sign-plus-digit count. If the text,
// NUL included, exceeds the buffer length, a single word with m_tuser
// (overflow) set, character 0 and count 0 is sent instead. An item occupies
// the block for the shift phase, a settle step for the digit count and
// overflow check, and the output words (1 to 21), sent one per cycle while
// m_tready is high; a new input is taken only once the item is done.
// The shift chain takes in one operand bit per cycle.
// The last word sits in the output register while the next input is taken.
module binary_to_decimal_ascii_top (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] value, [71:64] max_len, [72] append_terminator, [79:73] zero
    input  logic [b2d_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] signed_mode
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] char_code, [12:8] char_count, [15:13] zero
    output logic [b2d_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    // [0] overflow
    output logic                           m_tuser
);
    import b2d_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Operand and request fields; all but the shifting magnitude and step are held for the whole item.
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  term_reg, term_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // Digit count, tracked while the chain fills.
    logic [ND_W-1:0]       nd_reg, nd_next;

    // Emission sequencer.
    logic                  ovf_reg, ovf_next;
    logic [COUNT_W-1:0]    chars_reg, chars_next;
    logic                  sign_pend_reg, sign_pend_next;
    logic                  dig_pend_reg, dig_pend_next;
    logic [DIG_IDX_W-1:0]  idx_reg, idx_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]     m_char_reg, m_char_next;
    logic                  m_last_reg, m_last_next;
    logic                  m_ovf_reg, m_ovf_next;
    logic [COUNT_W-1:0]    m_cnt_reg, m_cnt_next;

    chain_ctrl_t           chain_ctrl;
    digit_t                digits [MAX_DIGITS];

    logic                  in_fire;
    logic [VALUE_BITS-1:0] in_value;
    logic                  in_neg;
    logic                  next_nonzero;
    logic [COUNT_W-1:0]    chars_calc;
    logic [LEN_W:0]        total_calc;
    logic                  ovf_calc;
    logic                  out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_neg   = s_tuser && in_value[VALUE_BITS-1];

    assign chain_ctrl.clear = in_fire;
    assign chain_ctrl.shift = (state_reg == ST_CONV);

    b2d_chain u_chain (
        .aclk  (aclk),
        .ctrl  (chain_ctrl),
        .bit_in(mag_reg[VALUE_BITS-1]),
        .digits(digits)
    );

    // The decimal length grows by at most one digit per doubling, so only
    // the decade just above the current top needs watching.
    always_comb begin
        next_nonzero = 1'b0;
        if (nd_reg < ND_W'(MAX_DIGITS)) begin
            next_nonzero = (digits[nd_reg[DIG_IDX_W-1:0]] != '0);
        end
    end

    always_comb begin
        chars_calc = COUNT_W'(nd_next) + COUNT_W'(neg_reg);
        total_calc = (LEN_W+1)'(chars_calc) + (LEN_W+1)'(term_reg);
        ovf_calc   = (total_calc > {1'b0, len_reg});
    end

    assign out_load = !m_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        term_next      = term_reg;
        len_next       = len_reg;
        step_next      = step_reg;
        nd_next        = nd_reg;
        ovf_next       = ovf_reg;
        chars_next     = chars_reg;
        sign_pend_next = sign_pend_reg;
        dig_pend_next  = dig_pend_reg;
        idx_next       = idx_reg;

        m_valid_next   = m_valid_reg && !m_tready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        m_ovf_next     = m_ovf_reg;
        m_cnt_next     = m_cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    mag_next   = in_neg ? (~in_value + 1'b1) : in_value;
                    neg_next   = in_neg;
                    term_next  = s_tdata[VALUE_BITS+LEN_W];
                    len_next   = s_tdata[VALUE_BITS +: LEN_W];
                    step_next  = '0;
                    nd_next    = ND_W'(1);
                    state_next = ST_CONV;
                end
            end

            ST_CONV: begin
                // Shift the magnitude in, most significant bit first.
                mag_next  = {mag_reg[VALUE_BITS-2:0], 1'b0};
                nd_next   = nd_reg + ND_W'(next_nonzero);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(VALUE_BITS - 1)) begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK: begin
                // Final digit count settles here; decide fit against the buffer.
                nd_next        = nd_reg + ND_W'(next_nonzero);
                ovf_next       = ovf_calc;
                chars_next     = chars_calc;
                sign_pend_next = neg_reg && !ovf_calc;
                dig_pend_next  = !ovf_calc;
                idx_next       = DIG_IDX_W'(nd_next - 1'b1);
                state_next     = ST_EMIT;
            end

            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    priority if (ovf_reg) begin
                        m_char_next = CHAR_NUL;
                        m_last_next = 1'b1;
                        m_ovf_next  = 1'b1;
                        m_cnt_next  = '0;
                        state_next  = ST_IDLE;
                    end else if (sign_pend_reg) begin
                        m_char_next    = CHAR_MINUS;
                        m_last_next    = 1'b0;
                        m_ovf_next     = 1'b0;
                        m_cnt_next     = '0;
                        sign_pend_next = 1'b0;
                    end else if (dig_pend_reg) begin
                        m_char_next = CHAR_ZERO + {4'b0000, digits[idx_reg]};
                        m_ovf_next  = 1'b0;
                        if (idx_reg == '0) begin
                            dig_pend_next = 1'b0;
                            m_last_next   = !term_reg;
                            m_cnt_next    = term_reg ? '0 : chars_reg;
                            if (!term_reg) begin
                                state_next = ST_IDLE;
                            end
                        end else begin
                            idx_next    = idx_reg - 1'b1;
                            m_last_next = 1'b0;
                            m_cnt_next  = '0;
                        end
                    end else begin
                        m_char_next = CHAR_NUL;
                        m_last_next = 1'b1;
                        m_ovf_next  = 1'b0;
                        m_cnt_next  = chars_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        term_reg      <= term_next;
        len_reg       <= len_next;
        step_reg      <= step_next;
        nd_reg        <= nd_next;
        ovf_reg       <= ovf_next;
        chars_reg     <= chars_next;
        sign_pend_reg <= sign_pend_next;
        dig_pend_reg  <= dig_pend_next;
        idx_reg       <= idx_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        m_ovf_reg     <= m_ovf_next;
        m_cnt_reg     <= m_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CHAR_W - COUNT_W)'(0), m_cnt_reg, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_ovf_reg;

endmodule

@@ sim/binary_to_decimal_ascii_top_tb.sv @@
// Self-checking bench for binary_to_decimal_ascii_top: converts 64-bit operands and checks the
// ASCII character stream word by word against typed expected text or an in-bench decimal predictor.
// Depends on b2d_pkg and the converter RTL; needs no files or arguments.
module binary_to_decimal_ascii_top_tb;
    import b2d_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SETTLE_CYCLES    = 100;
    localparam int RANDOM_PER_PHASE = 66;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    // One expected output word.
    typedef struct packed {
        logic [CHAR_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               ovf;
    } text_word_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TEXT, ROW_OVERFLOW} row_kind_e;

    // One conversion request; typed rows carry their expected text.
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  sgn;
        logic [LEN_W-1:0]      len;
        logic                  term;
        row_kind_e             kind;
        string                 txt;
    } conv_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    text_word_t expected_chars[$];
    int mismatches     = 0;
    int conversions    = 0;
    int negative_items = 0;
    int overflow_items = 0;
    int words_checked  = 0;
    int tx_idle_pct    = 25;
    int rx_idle_pct    = 83;
    int stall_cycles   = 0;

    // Extremes, zero buffer, too-long text, most negative value, NUL handling.
    conv_row_t directed_rows[24] = '{
        '{64'd0, 1'b0, 8'd255, 1'b0, ROW_TEXT, "0"},
        '{64'd0, 1'b0, 8'd1, 1'b1, ROW_OVERFLOW, ""},
        '{64'd0, 1'b1, 8'd2, 1'b1, ROW_TEXT, "0"},
        '{64'd7, 1'b0, 8'd0, 1'b0, ROW_OVERFLOW, ""},
        '{64'd7, 1'b0, 8'd1, 1'b0, ROW_TEXT, "7"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd20, 1'b0, ROW_TEXT, "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd19, 1'b0, ROW_OVERFLOW, ""},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd21, 1'b1, ROW_TEXT, "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd20, 1'b1, ROW_OVERFLOW, ""},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd2, 1'b0, ROW_TEXT, "-1"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd2, 1'b1, ROW_OVERFLOW, ""},
        '{64'h8000_0000_0000_0000, 1'b1, 8'd20, 1'b0, ROW_TEXT, "-9223372036854775808"},
        '{64'h8000_0000_0000_0000, 1'b1, 8'd21, 1'b1, ROW_TEXT, "-9223372036854775808"},
        '{64'h8000_0000_0000_0000, 1'b1, 8'd20, 1'b1, ROW_OVERFLOW, ""},
        '{64'h8000_0000_0000_0000, 1'b0, 8'd255, 1'b1, ROW_TEXT, "9223372036854775808"},
        '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'd19, 1'b0, ROW_TEXT, "9223372036854775807"},
        '{64'd10, 1'b0, 8'd1, 1'b0, ROW_OVERFLOW, ""},
        '{64'd10, 1'b1, 8'd3, 1'b1, ROW_TEXT, "10"},
        '{64'hFFFF_FFFF_FFFF_FF9C, 1'b1, 8'd4, 1'b0, ROW_TEXT, "-100"},
        '{64'hFFFF_FFFF_FFFF_FF9C, 1'b1, 8'd4, 1'b1, ROW_OVERFLOW, ""},
        '{64'h5555_5555_5555_5555, 1'b1, 8'd255, 1'b0, ROW_PREDICT, ""},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 8'd255, 1'b1, ROW_PREDICT, ""},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 8'hAA, 1'b0, ROW_PREDICT, ""},
        '{64'd1234567890, 1'b1, 8'h55, 1'b1, ROW_PREDICT, ""}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    binary_to_decimal_ascii_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Sign and digits of the operand, most significant character first.
    function automatic char_q_t decimal_chars(input logic [VALUE_BITS-1:0] v, input logic sgn);
        char_q_t               txt;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
        neg = sgn && v[VALUE_BITS-1];
        mag = neg ? -v : v;
        do begin
            txt.push_front(CHAR_ZERO + CHAR_W'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 0);
        if (neg) begin
            txt.push_front(CHAR_MINUS);
        end
        return txt;
    endfunction

    function automatic void push_text(input char_q_t txt, input logic term);
        text_word_t w;
        for (int i = 0; i < txt.size(); i++) begin
            w.code  = txt[i];
            w.last  = (i == txt.size() - 1) && !term;
            w.count = w.last ? COUNT_W'(txt.size()) : '0;
            w.ovf   = 1'b0;
            expected_chars.push_back(w);
        end
        if (term) begin
            w.code  = CHAR_NUL;
            w.last  = 1'b1;
            w.count = COUNT_W'(txt.size());
            w.ovf   = 1'b0;
            expected_chars.push_back(w);
        end
    endfunction

    function automatic void push_overflow();
        text_word_t w;
        w.code  = '0;
        w.count = '0;
        w.last  = 1'b1;
        w.ovf   = 1'b1;
        expected_chars.push_back(w);
        overflow_items++;
    endfunction

    function automatic void predict_conversion(input conv_row_t row);
        char_q_t txt;
        txt = decimal_chars(row.value, row.sgn);
        if (txt.size() + int'(row.term) > int'(row.len)) begin
            push_overflow();
        end else begin
            push_text(txt, row.term);
        end
    endfunction

    // Random request: mostly texts that fit, some that miss by one, some arbitrary lengths.
    function automatic conv_row_t random_conversion();
        conv_row_t             row;
        logic [VALUE_BITS-1:0] p;
        char_q_t               txt;
        int                    need;
        row.kind = ROW_PREDICT;
        row.txt  = "";
        row.sgn  = 1'($urandom_range(0, 1));
        row.term = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: row.value = {$urandom, $urandom};
            1, 2, 3: row.value = {$urandom, $urandom} >> $urandom_range(1, 63);
            4: row.value = 64'($urandom_range(0, 20));
            5: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                row.value = p - 64'd1 + 64'($urandom_range(0, 2));
            end
            6: row.value = -64'($urandom_range(1, 1000));
            default: row.value = {1'b1, 31'($urandom), $urandom};
        endcase
        txt  = decimal_chars(row.value, row.sgn);
        need = txt.size() + int'(row.term);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: row.len = LEN_W'(need + $urandom_range(0, 3));
            6: row.len = LEN_W'(need - 1);
            7, 8: row.len = LEN_W'($urandom_range(0, 255));
            default: row.len = 8'd255;
        endcase
        return row;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // with s_tvalid still high so the next word can follow back to back.
    task automatic send_conversion(input conv_row_t row);
        char_q_t typed;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, row.term, row.len, row.value};
        s_tuser  <= row.sgn;
        do @(posedge aclk); while (!s_tready);
        case (row.kind)
            ROW_TEXT: begin
                for (int i = 0; i < row.txt.len(); i++) typed.push_back(row.txt[i]);
                push_text(typed, row.term);
            end
            ROW_OVERFLOW: push_overflow();
            default: predict_conversion(row);
        endcase
        conversions++;
        if (row.sgn && row.value[VALUE_BITS-1]) begin
            negative_items++;
        end
        @(negedge aclk);
    endtask

    // Hold the sender off until every predicted word has been seen.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_chars.size() != 0) @(negedge aclk);
    endtask

    // Receiver: roll m_tready every cycle against the current idle rate.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each accepted word against the oldest prediction.
    always @(posedge aclk) begin : char_monitor
        text_word_t got;
        text_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.code  = m_tdata[7:0];
            got.count = m_tdata[12:8];
            got.last  = m_tlast;
            got.ovf   = m_tuser;
            words_checked++;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%h count=%0d last=%b ovf=%b",
                                          got.code, got.count, got.last, got.ovf));
            end else begin
                want = expected_chars.pop_front();
                if (got != want) begin
                    report_mismatch($sformatf(
                        "char=%h/%h count=%0d/%0d last=%b/%b ovf=%b/%b (got/want)",
                        got.code, want.code, got.count, want.count,
                        got.last, want.last, got.ovf, want.ovf));
                end
            end
        end
    end

    // Abort when neither side moves a word for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     stall_cycles, expected_chars.size());
            $display("binary_to_decimal_ascii_top verification failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) send_conversion(directed_rows[i]);
        drain_outputs();

        // Sender busy / receiver mostly idle, then swapped, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 83 : 0;
            rx_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 25 : 0;
            repeat (RANDOM_PER_PHASE) send_conversion(random_conversion());
            drain_outputs();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("ran %0d conversions (%0d negative, %0d overflow) under three idle mixes",
                 conversions, negative_items, overflow_items);
        $display("checked %0d character words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("binary_to_decimal_ascii_top verification clean");
        end else begin
            $display("binary_to_decimal_ascii_top verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/b2d_pkg.sv
rtl/core/b2d_cell.sv
rtl/core/b2d_chain.sv
rtl/core/binary_to_decimal_ascii_top.sv
sim/binary_to_decimal_ascii_top_tb.sv
